// ===== sv/sar_pkg.sv =====
// Shared types and constants for the spectral affine reconstruction block.
`timescale 1ns / 1ps

package sar_pkg;

    localparam int MAX_REFS_DEF  = 256;
    localparam int MAX_BANDS_DEF = 64;

    localparam int NUM_REFS_W  = 9;
    localparam int NUM_BANDS_W = 7;
    localparam int REF_W       = 8;
    localparam int BAND_W      = 6;
    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 24;
    localparam int OFFSET_W    = 24;
    localparam int PROD_W      = GAIN_W + SAMPLE_W;
    localparam int ACC_W       = PROD_W + 1;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int OFIFO_DEPTH = 8;

    localparam logic [NUM_REFS_W-1:0]  NUM_REFS_RST  = NUM_REFS_W'(256);
    localparam logic [NUM_BANDS_W-1:0] NUM_BANDS_RST = NUM_BANDS_W'(64);

    typedef enum logic {
        MODE_LOAD  = 1'b0,
        MODE_PIXEL = 1'b1
    } mode_t;

    typedef enum logic {
        REG_NUM_REFS  = 1'b0,
        REG_NUM_BANDS = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

    typedef struct packed {
        mode_t                       mode;
        logic [REF_W-1:0]            ref_idx;
        logic [BAND_W-1:0]           band;
        logic signed [SAMPLE_W-1:0]  value;
        logic signed [GAIN_W-1:0]    gain;
        logic signed [OFFSET_W-1:0]  offset;
        logic                        ref_ok;
        logic [NUM_BANDS_W-1:0]      bands;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [BAND_W-1:0]          band;
        logic                       last;
        logic                       ok;
    } out_t;

endpackage

// ===== sv/spectral_affine_reconstruct.sv =====
// Top level: spectral affine reconstruction from a store of reference spectra.
// Loads give no result.
// A load is written to the reference memory as it leaves the queue; none leaves mid-pixel.
// Pixels read one band per cycle from its single read port while result credits remain.
// Reset: clears control, sets num_refs to 256 and num_bands to 64.
// The reference memory is not cleared and holds no value until written.
`timescale 1ns / 1ps

module spectral_affine_reconstruct
    import sar_pkg::*;
#(
    parameter int MAX_REFS  = MAX_REFS_DEF,
    parameter int MAX_BANDS = MAX_BANDS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [APB_AW-1:0]           paddr,
    input  logic [APB_DW-1:0]           pwdata,
    output logic [APB_DW-1:0]           prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        mode,
    input  logic [REF_W-1:0]            spectrum_index,
    input  logic [BAND_W-1:0]           band_index,
    input  logic signed [SAMPLE_W-1:0]  load_value,
    input  logic signed [GAIN_W-1:0]    gain,
    input  logic signed [OFFSET_W-1:0]  offset,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [SAMPLE_W-1:0]  sample,
    output logic [BAND_W-1:0]           band_out,
    output logic                        last_band,
    output logic                        index_valid
);

    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_valid;
    item_t q_in;
    item_t q_head;

    sar_front #(
        .MAX_REFS  (MAX_REFS),
        .MAX_BANDS (MAX_BANDS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .spectrum_index (spectrum_index),
        .band_index     (band_index),
        .load_value     (load_value),
        .gain           (gain),
        .offset         (offset),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_item         (q_in)
    );

    sar_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    sar_back #(
        .MAX_REFS  (MAX_REFS),
        .MAX_BANDS (MAX_BANDS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sample      (sample),
        .band_out    (band_out),
        .last_band   (last_band),
        .index_valid (index_valid)
    );

endmodule

// ===== sv/sar_front.sv =====
// Front end: configuration registers, input acceptance and item classification.
`timescale 1ns / 1ps

module sar_front
    import sar_pkg::*;
#(
    parameter int MAX_REFS  = MAX_REFS_DEF,
    parameter int MAX_BANDS = MAX_BANDS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_AW-1:0]          paddr,
    input  logic [APB_DW-1:0]          pwdata,
    output logic [APB_DW-1:0]          prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       mode,
    input  logic [REF_W-1:0]           spectrum_index,
    input  logic [BAND_W-1:0]          band_index,
    input  logic signed [SAMPLE_W-1:0] load_value,
    input  logic signed [GAIN_W-1:0]   gain,
    input  logic signed [OFFSET_W-1:0] offset,
    input  logic                       q_full,
    output logic                       q_push,
    output item_t                      q_item
);

    logic [NUM_REFS_W-1:0]  num_refs_reg;
    logic [NUM_BANDS_W-1:0] num_bands_reg;
    logic                   cfg_wr;
    cfg_reg_t               cfg_sel;
    logic                   ref_ok;
    logic [NUM_BANDS_W-1:0] bands;

    assign pready  = 1'b1;
    assign cfg_sel = cfg_reg_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            num_refs_reg  <= NUM_REFS_RST;
            num_bands_reg <= NUM_BANDS_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_NUM_REFS:  num_refs_reg  <= pwdata[NUM_REFS_W-1:0];
                REG_NUM_BANDS: num_bands_reg <= pwdata[NUM_BANDS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_NUM_REFS:  prdata = APB_DW'(num_refs_reg);
            REG_NUM_BANDS: prdata = APB_DW'(num_bands_reg);
            default:       prdata = '0;
        endcase
    end

    // Classify: reference in range, band count clamped to the store width.
    assign ref_ok = (NUM_REFS_W'(spectrum_index) < num_refs_reg) &&
                    (32'(spectrum_index) < 32'(MAX_REFS));
    assign bands  = (32'(num_bands_reg) > 32'(MAX_BANDS)) ?
                    NUM_BANDS_W'(MAX_BANDS) : num_bands_reg;

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;

    always_comb
    begin
        q_item.mode    = mode_t'(mode);
        q_item.ref_idx = spectrum_index;
        q_item.band    = band_index;
        q_item.value   = load_value;
        q_item.gain    = gain;
        q_item.offset  = offset;
        q_item.ref_ok  = ref_ok;
        q_item.bands   = bands;
    end

endmodule

// ===== sv/sar_queue.sv =====
// Short queue of classified transactions between front and back ends.
`timescale 1ns / 1ps

module sar_queue
    import sar_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  valid,
    output item_t head
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    item_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;

    assign full  = (count_reg == CW'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CW'(push) - CW'(pop);
        end
    end

    always_ff @(posedge clk) begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/sar_back.sv =====
// Back end: reference store, band sequencer, multiply-add pipeline and result FIFO.
`timescale 1ns / 1ps

module sar_back
    import sar_pkg::*;
#(
    parameter int MAX_REFS  = MAX_REFS_DEF,
    parameter int MAX_BANDS = MAX_BANDS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  item_t                       q_item,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [SAMPLE_W-1:0]  sample,
    output logic [BAND_W-1:0]           band_out,
    output logic                        last_band,
    output logic                        index_valid
);

    localparam int DEPTH = MAX_REFS * MAX_BANDS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OPW   = $clog2(OFIFO_DEPTH);
    localparam int CW    = $clog2(OFIFO_DEPTH + 1);

    back_state_t state_reg;
    back_state_t state_next;

    logic [SAMPLE_W-1:0]         mem [DEPTH];
    logic signed [SAMPLE_W-1:0]  mem_q_reg;

    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [AW-1:0]               rd_addr;
    logic                        start;
    logic                        issue;
    logic                        band_last;

    logic [BAND_W-1:0]           band_reg;
    logic [NUM_BANDS_W-1:0]      bands_reg;
    logic [AW-1:0]               base_reg;
    logic                        cur_ok_reg;
    logic signed [GAIN_W-1:0]    cur_gain_reg;
    logic signed [OFFSET_W-1:0]  cur_offset_reg;

    logic                        s1_v_reg;
    logic [BAND_W-1:0]           s1_band_reg;
    logic                        s1_last_reg;
    logic                        s1_ok_reg;
    logic signed [GAIN_W-1:0]    s1_gain_reg;
    logic signed [OFFSET_W-1:0]  s1_offset_reg;

    logic                        s2_v_reg;
    logic [BAND_W-1:0]           s2_band_reg;
    logic                        s2_last_reg;
    logic                        s2_ok_reg;
    logic signed [OFFSET_W-1:0]  s2_offset_reg;
    logic signed [PROD_W-1:0]    s2_prod_reg;

    logic                        s3_v_reg;
    logic [BAND_W-1:0]           s3_band_reg;
    logic                        s3_last_reg;
    logic                        s3_ok_reg;
    logic signed [ACC_W-1:0]     s3_acc_reg;

    logic                        acc_neg;
    logic [ACC_W-1:0]            acc_mag;
    logic [ACC_W:0]              acc_rnd;
    logic [ACC_W-16:0]           acc_q;
    logic signed [SAMPLE_W-1:0]  sat_val;
    out_t                        push_res;

    out_t                        ofifo_reg [OFIFO_DEPTH];
    logic [OPW-1:0]              owr_ptr_reg;
    logic [OPW-1:0]              ord_ptr_reg;
    logic [CW-1:0]               ocount_reg;
    logic [CW-1:0]               cred_reg;
    logic                        opop;
    out_t                        ohead;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: if (start) state_next = BK_RUN;
            BK_RUN:  if (issue && band_last) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        q_pop = 1'b0;
        issue = 1'b0;
        unique case (state_reg)
            BK_IDLE: q_pop = q_valid;
            BK_RUN:  issue = (cred_reg != '0);
            default: ;
        endcase
    end

    assign band_last = ((NUM_BANDS_W'(band_reg) + 1'b1) == bands_reg);
    assign start     = q_pop && (q_item.mode == MODE_PIXEL) && (q_item.bands != '0);
    assign wr_en     = q_pop && (q_item.mode == MODE_LOAD) &&
                       (32'(q_item.ref_idx) < 32'(MAX_REFS)) &&
                       (32'(q_item.band) < 32'(MAX_BANDS));
    assign wr_addr   = AW'(32'(q_item.ref_idx) * MAX_BANDS + 32'(q_item.band));
    assign rd_addr   = base_reg + AW'(band_reg);

    always_ff @(posedge clk) begin
        if (wr_en)
        begin
            mem[wr_addr] <= q_item.value;
        end
        mem_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            band_reg  <= '0;
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (start)
            begin
                band_reg <= '0;
            end
            else if (issue)
            begin
                band_reg <= band_reg + 1'b1;
            end
            s1_v_reg <= issue;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    // Hold pixel context and carry it down the pipeline
    always_ff @(posedge clk) begin
        if (start)
        begin
            bands_reg      <= q_item.bands;
            cur_ok_reg     <= q_item.ref_ok;
            cur_gain_reg   <= q_item.gain;
            cur_offset_reg <= q_item.offset;
            base_reg       <= q_item.ref_ok ? AW'(32'(q_item.ref_idx) * MAX_BANDS) : '0;
        end
        s1_band_reg   <= band_reg;
        s1_last_reg   <= band_last;
        s1_ok_reg     <= cur_ok_reg;
        s1_gain_reg   <= cur_gain_reg;
        s1_offset_reg <= cur_offset_reg;

        s2_band_reg   <= s1_band_reg;
        s2_last_reg   <= s1_last_reg;
        s2_ok_reg     <= s1_ok_reg;
        s2_offset_reg <= s1_offset_reg;
        s2_prod_reg   <= s1_gain_reg * mem_q_reg;

        s3_band_reg   <= s2_band_reg;
        s3_last_reg   <= s2_last_reg;
        s3_ok_reg     <= s2_ok_reg;
        s3_acc_reg    <= ACC_W'(s2_prod_reg) + (ACC_W'(s2_offset_reg) <<< 8);
    end

    // Round half away from zero, then saturate
    always_comb
    begin
        acc_neg = s3_acc_reg[ACC_W-1];
        acc_mag = acc_neg ? (~s3_acc_reg + 1'b1) : s3_acc_reg;
        acc_rnd = {1'b0, acc_mag} + (ACC_W+1)'(32768);
        acc_q   = acc_rnd[ACC_W:16];
        if (acc_neg)
        begin
            sat_val = (acc_q > (ACC_W-15)'(32768)) ? 16'sh8000 : -$signed(acc_q[15:0]);
        end
        else
        begin
            sat_val = (acc_q > (ACC_W-15)'(32767)) ? 16'sh7fff : $signed(acc_q[15:0]);
        end
        push_res.sample = s3_ok_reg ? sat_val : '0;
        push_res.band   = s3_band_reg;
        push_res.last   = s3_last_reg;
        push_res.ok     = s3_ok_reg;
    end

    // Result FIFO, space reserved by credits at issue time
    assign opop      = out_valid && out_ready;
    assign out_valid = (ocount_reg != '0);
    assign ohead     = ofifo_reg[ord_ptr_reg];
    assign sample      = ohead.sample;
    assign band_out    = ohead.band;
    assign last_band   = ohead.last;
    assign index_valid = ohead.ok;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            owr_ptr_reg <= '0;
            ord_ptr_reg <= '0;
            ocount_reg  <= '0;
            cred_reg    <= CW'(OFIFO_DEPTH);
        end
        else
        begin
            if (s3_v_reg)
            begin
                owr_ptr_reg <= owr_ptr_reg + 1'b1;
            end
            if (opop)
            begin
                ord_ptr_reg <= ord_ptr_reg + 1'b1;
            end
            ocount_reg <= ocount_reg + CW'(s3_v_reg) - CW'(opop);
            cred_reg   <= cred_reg - CW'(issue) + CW'(opop);
        end
    end

    always_ff @(posedge clk) begin
        if (s3_v_reg)
        begin
            ofifo_reg[owr_ptr_reg] <= push_res;
        end
    end

    a_cred_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (cred_reg + ocount_reg + CW'(s1_v_reg) + CW'(s2_v_reg) + CW'(s3_v_reg))
            == CW'(OFIFO_DEPTH))
        else $error("credit count out of balance with FIFO and pipeline");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        s3_v_reg |-> (ocount_reg != CW'(OFIFO_DEPTH)) || opop)
        else $error("result FIFO written while full");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == BK_IDLE) && !issue)
        else $error("queue popped while a pixel is in progress");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && band_last) |=> (state_reg == BK_IDLE) && s1_v_reg && s1_last_reg)
        else $error("final band did not end the pixel");

endmodule

// ===== test/spectral_affine_reconstruct_test.sv =====
// Testbench for spectral_affine_reconstruct: reference loads and pixels against a built-in predictor.
`timescale 1ns / 1ps

module spectral_affine_reconstruct_test
    import sar_pkg::*;
;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [APB_AW-1:0]          paddr;
    logic [APB_DW-1:0]          pwdata;
    logic [APB_DW-1:0]          prdata;
    logic                       pready;
    logic                       in_valid;
    logic                       in_ready;
    logic                       mode;
    logic [REF_W-1:0]           spectrum_index;
    logic [BAND_W-1:0]          band_index;
    logic signed [SAMPLE_W-1:0] load_value;
    logic signed [GAIN_W-1:0]   gain;
    logic signed [OFFSET_W-1:0] offset;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] sample;
    logic [BAND_W-1:0]          band_out;
    logic                       last_band;
    logic                       index_valid;

    out_t                       expected_bands[$];
    logic signed [SAMPLE_W-1:0] spectra[MAX_REFS_DEF][MAX_BANDS_DEF];
    bit                         loaded[MAX_REFS_DEF][MAX_BANDS_DEF];
    logic [NUM_REFS_W-1:0]      refs_cfg;
    logic [NUM_BANDS_W-1:0]     bands_cfg;
    int                         mismatches = 0;
    int                         send_idle_pct = 0;
    int                         recv_idle_pct = 0;

    spectral_affine_reconstruct dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .spectrum_index (spectrum_index),
        .band_index     (band_index),
        .load_value     (load_value),
        .gain           (gain),
        .offset         (offset),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sample         (sample),
        .band_out       (band_out),
        .last_band      (last_band),
        .index_valid    (index_valid)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic int effective_bands();
        return (bands_cfg > MAX_BANDS_DEF) ? MAX_BANDS_DEF : int'(bands_cfg);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] round_saturate(longint acc);
        longint mag;
        longint q;
        mag = (acc < 0) ? -acc : acc;
        q = (mag + 32768) >>> 16;
        if (acc < 0)
        begin
            if (q > 32768)
                q = 32768;
            return SAMPLE_W'(-q);
        end
        if (q > 32767)
            q = 32767;
        return SAMPLE_W'(q);
    endfunction

    task automatic predict_reconstruction(logic [REF_W-1:0] ref_id,
                                          logic signed [GAIN_W-1:0] g,
                                          logic signed [OFFSET_W-1:0] o);
        out_t   res;
        int     nb;
        bit     ok;
        longint acc;
        nb = effective_bands();
        ok = (ref_id < refs_cfg);
        for (int b = 0; b < nb; b++)
        begin
            res.sample = '0;
            if (ok)
            begin
                acc = longint'(g) * longint'(spectra[ref_id][b]) + longint'(o) * 256;
                res.sample = round_saturate(acc);
            end
            res.band = BAND_W'(b);
            res.last = (b + 1 == nb);
            res.ok = ok;
            expected_bands.push_back(res);
        end
    endtask

    task automatic send_item(mode_t m, logic [REF_W-1:0] ref_id, logic [BAND_W-1:0] b,
                             logic signed [SAMPLE_W-1:0] v, logic signed [GAIN_W-1:0] g,
                             logic signed [OFFSET_W-1:0] o);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        mode           <= m;
        spectrum_index <= ref_id;
        band_index     <= b;
        load_value     <= v;
        gain           <= g;
        offset         <= o;
        do
            @(posedge clk);
        while (!in_ready);
        if (m == MODE_LOAD)
        begin
            spectra[ref_id][b] = v;
            loaded[ref_id][b] = 1'b1;
        end
        else
            predict_reconstruction(ref_id, g, o);
    endtask

    task automatic load_sample(logic [REF_W-1:0] ref_id, logic [BAND_W-1:0] b,
                               logic signed [SAMPLE_W-1:0] v);
        send_item(MODE_LOAD, ref_id, b, v, GAIN_W'($urandom), OFFSET_W'($urandom));
    endtask

    task automatic reconstruct(logic [REF_W-1:0] ref_id, logic signed [GAIN_W-1:0] g,
                               logic signed [OFFSET_W-1:0] o);
        send_item(MODE_PIXEL, ref_id, BAND_W'($urandom), SAMPLE_W'($urandom), g, o);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_bands.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_register(cfg_reg_t r, int unsigned value);
        drain_results();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * int'(r));
        pwdata  <= APB_DW'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (r == REG_NUM_REFS)
            refs_cfg = NUM_REFS_W'(value);
        else
            bands_cfg = NUM_BANDS_W'(value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bands.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected band: sample %0d band %0d last %0b ok %0b",
                         $time, sample, band_out, last_band, index_valid);
            end
            else
            begin
                if (sample !== expected_bands[0].sample || band_out !== expected_bands[0].band
                    || last_band !== expected_bands[0].last
                    || index_valid !== expected_bands[0].ok)
                begin
                    mismatches++;
                    $display({"%0t: expected sample %0d band %0d last %0b ok %0b, ",
                              "got sample %0d band %0d last %0b ok %0b"},
                             $time, expected_bands[0].sample, expected_bands[0].band,
                             expected_bands[0].last, expected_bands[0].ok,
                             sample, band_out, last_band, index_valid);
                end
                void'(expected_bands.pop_front());
            end
        end
    end

    task automatic test_extremes_and_ties();
        send_idle_pct = 27;
        recv_idle_pct = 66;
        write_register(REG_NUM_BANDS, 4);
        load_sample(8'd0, 6'd0, 16'sh7FFF);
        load_sample(8'd0, 6'd1, 16'sh8000);
        load_sample(8'd0, 6'd2, 16'sh0000);
        load_sample(8'd0, 6'd3, -16'sd1);
        load_sample(8'd255, 6'd0, 16'sd1);
        load_sample(8'd255, 6'd1, -16'sd1);
        load_sample(8'd255, 6'd2, 16'sd3);
        load_sample(8'd255, 6'd3, -16'sd3);
        load_sample(8'd255, 6'd63, SAMPLE_W'($urandom));
        reconstruct(8'd0, 24'sh7FFFFF, 24'sh7FFFFF);
        reconstruct(8'd0, 24'sh800000, 24'sh800000);
        reconstruct(8'd0, 24'sd0, 24'sd0);
        reconstruct(8'd255, 24'sd32768, 24'sd0);
        reconstruct(8'd255, 24'sd0, 24'sd128);
        reconstruct(8'd255, 24'sd0, -24'sd128);
        reconstruct(8'd0, 24'sd65536, 24'sd0);
    endtask

    task automatic test_reference_limits();
        write_register(REG_NUM_REFS, 1);
        reconstruct(8'd0, 24'sd65536, 24'sd256);
        reconstruct(8'd1, 24'sd65536, 24'sd256);
        reconstruct(8'd255, 24'sd65536, 24'sd256);
        write_register(REG_NUM_REFS, 0);
        reconstruct(8'd0, 24'sd65536, 24'sd0);
        write_register(REG_NUM_REFS, 511);
        write_register(REG_NUM_BANDS, 1);
        reconstruct(8'd255, -24'sd65536, 24'sd0);
        write_register(REG_NUM_BANDS, 0);
        reconstruct(8'd0, 24'sd65536, 24'sd0);
        reconstruct(8'd255, 24'sd65536, 24'sd0);
    endtask

    task automatic run_random(int item_budget);
        int                         sent;
        logic [REF_W-1:0]           ref_id;
        logic signed [GAIN_W-1:0]   g;
        logic signed [OFFSET_W-1:0] o;
        logic signed [SAMPLE_W-1:0] v;
        sent = 0;
        while (sent < item_budget)
        begin
            ref_id = ($urandom_range(99) < 60) ? REF_W'($urandom_range(7)) : REF_W'($urandom);
            if ($urandom_range(99) < 30)
            begin
                v = SAMPLE_W'($urandom);
                load_sample(ref_id, BAND_W'($urandom), v >>> $urandom_range(8, 0));
                sent++;
            end
            else
            begin
                if (ref_id < refs_cfg)
                begin
                    for (int b = 0; b < effective_bands(); b++)
                    begin
                        if (!loaded[ref_id][b])
                        begin
                            v = SAMPLE_W'($urandom);
                            load_sample(ref_id, BAND_W'(b), v >>> $urandom_range(8, 0));
                            sent++;
                        end
                    end
                end
                g = GAIN_W'($urandom);
                o = OFFSET_W'($urandom);
                reconstruct(ref_id, g >>> $urandom_range(16, 0), o >>> $urandom_range(10, 0));
                sent++;
            end
        end
    endtask

    task automatic test_random_sender_slow();
        send_idle_pct = 27;
        recv_idle_pct = 66;
        write_register(REG_NUM_REFS, $urandom_range(256, 1));
        write_register(REG_NUM_BANDS, $urandom_range(8, 1));
        run_random(45);
    endtask

    task automatic test_random_receiver_slow();
        send_idle_pct = 66;
        recv_idle_pct = 27;
        write_register(REG_NUM_REFS, 300);
        write_register(REG_NUM_BANDS, 3);
        run_random(45);
    endtask

    task automatic test_random_full_rate();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_register(REG_NUM_REFS, 256);
        write_register(REG_NUM_BANDS, 64);
        run_random(10);
        write_register(REG_NUM_REFS, $urandom_range(16, 1));
        write_register(REG_NUM_BANDS, 100);
        run_random(10);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        mode           = MODE_LOAD;
        spectrum_index = '0;
        band_index     = '0;
        load_value     = '0;
        gain           = '0;
        offset         = '0;
        refs_cfg       = NUM_REFS_RST;
        bands_cfg      = NUM_BANDS_RST;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_extremes_and_ties();
        test_reference_limits();
        test_random_sender_slow();
        test_random_receiver_slow();
        test_random_full_rate();
        drain_results();
        if (mismatches == 0 && expected_bands.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/sar_pkg.sv
sv/sar_front.sv
sv/sar_queue.sv
sv/sar_back.sv
sv/spectral_affine_reconstruct.sv
test/spectral_affine_reconstruct_test.sv
